[rtl/rps_pkg.sv]
// Shared constants for the random permutation shuffle block.
`timescale 1ns / 1ps
`default_nettype none

package rps_pkg;

  // Largest permutation the store can hold.
  localparam int MAX_LENGTH = 64;

  // Store address width and the width of a length or position count.
  localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int LEN_W  = $clog2(MAX_LENGTH + 1);

  // Fixed field widths.
  localparam int ELEM_W = 6;
  localparam int RAND_W = 31;
  localparam int CFG_W  = 7;
  localparam int APB_W  = 32;
  localparam int PADDR_W = 2;

  // Divider: dividend bits retired per cycle and number of cycles.
  localparam int DIV_STEP   = 8;
  localparam int DIV_BITS   = ((RAND_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int DIV_CYCLES = DIV_BITS / DIV_STEP;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Reset value of the length register.
  localparam logic [CFG_W-1:0] LENGTH_RESET = CFG_W'(64);

endpackage

`default_nettype wire

[rtl/random_permutation_shuffle.sv]
// Top level of the random permutation shuffle block (forward Fisher-Yates).
`timescale 1ns / 1ps
`default_nettype none

// The block builds one permutation of 0..L-1 from L random words, L being
// perm_length (0 acts as 1, values above 64 act as 64). An item is taken when
// start is high and busy is low; each item performs one swap step and keeps
// busy high until the step is done, so no new item is taken before then. The
// step runs the remainder unit over the word 8 dividend bits at a time, reads both
// store entries on the two read ports, and writes them back one after the other
// through the single write port. The item that completes the permutation is
// followed by L result transactions on consecutive cycles, one store read each,
// with out_is_last on the final one; busy stays high while they are read, and the
// last result appears in the first cycle after busy falls. Results cannot be
// stalled: each one is valid for exactly one cycle, marked by out_valid. The
// store returns to identity at once after the last read or a write of
// perm_length, through per-entry valid bits, so no clearing pass is needed.
module random_permutation_shuffle (
  input  wire                       clk,
  input  wire                       rst_n,
  // Input channel
  input  wire                       start,
  output logic                      busy,
  input  wire [rps_pkg::RAND_W-1:0] in_random_value,
  // Result channel
  output logic                      out_valid,
  output logic [rps_pkg::ELEM_W-1:0] out_element,
  output logic                      out_is_last,
  // Configuration port
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire [rps_pkg::PADDR_W-1:0] paddr,
  input  wire [rps_pkg::APB_W-1:0]  pwdata,
  output logic [rps_pkg::APB_W-1:0] prdata,
  output logic                      pready
);
  import rps_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_WRA  = 3'd3;
  localparam logic [2:0] ST_WRB  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [CFG_W-1:0]      perm_len_r;
  logic [LEN_W-1:0]      pos_r, pos_nxt;
  logic [LEN_W-1:0]      len_eff;
  logic [LEN_W-1:0]      span_r;
  logic [ADDR_W-1:0]     i_r, j_r;
  logic [LEN_W-1:0]      k_r, k_nxt;
  logic [DIV_BITS-1:0]   div_r;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic                  emit_r, last_r;
  logic [MAX_LENGTH-1:0] vld_r;
  logic                  cfg_wr;
  logic                  accept;
  logic                  restart;

  // Store and its read registers.
  logic [ELEM_W-1:0]     mem [MAX_LENGTH];
  logic                  rd_en;
  logic [ADDR_W-1:0]     ra_a, ra_b;
  logic [ELEM_W-1:0]     rd_a_data_r, rd_b_data_r;
  logic                  rd_a_vld_r, rd_b_vld_r;
  logic [ADDR_W-1:0]     rd_a_addr_r, rd_b_addr_r;
  logic [ELEM_W-1:0]     rd_a_val, rd_b_val;
  logic                  we;
  logic [ADDR_W-1:0]     wa;
  logic [ELEM_W-1:0]     wd;

  // Configuration port: one register, writes complete in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr == '0) ? APB_W'(perm_len_r) : '0;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;

  // Effective length: zero acts as one, oversize clamps to the store depth.
  always_comb begin
    if (perm_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(perm_len_r) > 32'(MAX_LENGTH)) begin
      len_eff = LEN_W'(MAX_LENGTH);
    end else begin
      len_eff = LEN_W'(perm_len_r);
    end
  end

  // Remainder unit: restoring steps over the next group of dividend bits.
  always_comb begin
    logic [LEN_W:0] t;
    rem_nxt = rem_r;
    for (int b = 0; b < DIV_STEP; b++) begin
      t = {rem_nxt, div_r[DIV_BITS-1-b]};
      if (t >= {1'b0, span_r}) begin
        t = t - {1'b0, span_r};
      end
      rem_nxt = t[LEN_W-1:0];
    end
  end

  // Entries that were never written since the last restart read as identity.
  assign rd_a_val = rd_a_vld_r ? rd_a_data_r : ELEM_W'(rd_a_addr_r);
  assign rd_b_val = rd_b_vld_r ? rd_b_data_r : ELEM_W'(rd_b_addr_r);

  // Sequencer: memory port control and next-state logic.
  always_comb begin
    logic [LEN_W-1:0] j_sum;
    state_nxt = state_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    rd_en     = 1'b0;
    ra_a      = i_r;
    ra_b      = i_r;
    we        = 1'b0;
    wa        = j_r;
    wd        = rd_a_val;
    restart   = 1'b0;
    j_sum     = LEN_W'(i_r) + rem_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        ra_a      = i_r;
        ra_b      = j_sum[ADDR_W-1:0];
        state_nxt = ST_WRA;
      end
      ST_WRA: begin
        we        = 1'b1;
        wa        = j_r;
        wd        = rd_a_val;
        state_nxt = ST_WRB;
      end
      ST_WRB: begin
        we      = 1'b1;
        wa      = i_r;
        wd      = rd_b_val;
        pos_nxt = pos_r + LEN_W'(1);
        k_nxt   = '0;
        if (pos_nxt >= len_eff) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        rd_en = 1'b1;
        ra_a  = k_r[ADDR_W-1:0];
        ra_b  = k_r[ADDR_W-1:0];
        k_nxt = k_r + LEN_W'(1);
        if (k_nxt >= len_eff) begin
          state_nxt = ST_IDLE;
          restart   = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // A length write abandons the permutation in progress.
    if (cfg_wr) begin
      restart = 1'b1;
    end
    if (restart) begin
      pos_nxt = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      perm_len_r <= LENGTH_RESET;
      pos_r      <= '0;
      k_r        <= '0;
      div_cnt_r  <= '0;
      emit_r     <= 1'b0;
      last_r     <= 1'b0;
      vld_r      <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      k_r     <= k_nxt;
      emit_r  <= (state_r == ST_EMIT);
      last_r  <= (state_r == ST_EMIT) && (k_nxt >= len_eff);
      if (cfg_wr) begin
        perm_len_r <= pwdata[CFG_W-1:0];
      end
      if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end else begin
        div_cnt_r <= '0;
      end
      if (restart) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[wa] <= 1'b1;
      end
    end
  end

  // Datapath registers for the swap step in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      div_r  <= DIV_BITS'(in_random_value);
      rem_r  <= '0;
      i_r    <= pos_r[ADDR_W-1:0];
      span_r <= len_eff - pos_r;
    end else if (state_r == ST_DIV) begin
      div_r <= div_r << DIV_STEP;
      rem_r <= rem_nxt;
    end
    if (state_r == ST_READ) begin
      j_r <= ra_b;
    end
  end

  // Permutation store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_a_data_r <= mem[ra_a];
      rd_b_data_r <= mem[ra_b];
      rd_a_vld_r  <= vld_r[ra_a];
      rd_b_vld_r  <= vld_r[ra_b];
      rd_a_addr_r <= ra_a;
      rd_b_addr_r <= ra_b;
    end
  end

  // Result channel.
  assign out_valid   = emit_r;
  assign out_element = rd_a_val;
  assign out_is_last = last_r;

endmodule

`default_nettype wire

[tb/sv/random_permutation_shuffle_checker.sv]
// Checker for the permutation shuffle block: mirrors the shuffle state and compares every result.
`timescale 1ns / 1ps

module random_permutation_shuffle_checker
  import rps_pkg::*;
#(
  parameter logic [PADDR_W-1:0] LENGTH_ADDR = '0
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire                busy,
  input  wire [RAND_W-1:0]   in_random_value,
  input  wire                out_valid,
  input  wire [ELEM_W-1:0]   out_element,
  input  wire                out_is_last,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [PADDR_W-1:0]  paddr,
  input  wire [APB_W-1:0]    pwdata,
  input  wire [APB_W-1:0]    prdata,
  input  wire                pready,
  output int                 mismatch_count,
  output int                 results_owed
);

  // One emitted permutation entry.
  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              is_last;
  } perm_entry_t;

  // Mirrored state of the shuffle.
  logic [ELEM_W-1:0] shuffle_store [MAX_LENGTH];
  logic [LEN_W-1:0]  swap_pos;
  logic [CFG_W-1:0]  length_reg;
  perm_entry_t       owed_entries [$];
  int                fail_tally = 0;

  // Zero acts as one and anything above the store size acts as the store size.
  function automatic int unsigned active_length();
    int unsigned len;
    len = 32'(length_reg);
    if (len == 0) len = 1;
    if (len > MAX_LENGTH) len = MAX_LENGTH;
    return len;
  endfunction

  task automatic restore_identity();
    for (int k = 0; k < MAX_LENGTH; k++) begin
      shuffle_store[k] = ELEM_W'(k);
    end
    swap_pos = '0;
  endtask

  // One swap step; the step at the last position releases the whole permutation.
  task automatic shuffle_step(input logic [RAND_W-1:0] rnd);
    int unsigned len;
    int unsigned i;
    int unsigned j;
    int unsigned span;
    logic [ELEM_W-1:0] held;
    perm_entry_t entry;
    len = active_length();
    if (32'(swap_pos) >= len) restore_identity();
    i = 32'(swap_pos);
    span = len - i;
    j = i + (int'(rnd) % span);
    if (j >= len) j = len - 1;
    held = shuffle_store[i];
    shuffle_store[i] = shuffle_store[j];
    shuffle_store[j] = held;
    swap_pos = LEN_W'(i + 1);
    if (32'(swap_pos) == len) begin
      for (int unsigned k = 0; k < len; k++) begin
        entry.element = shuffle_store[k];
        entry.is_last = (k + 1 == len);
        owed_entries.push_back(entry);
      end
      restore_identity();
    end
  endtask

  // Compare one result transaction with the oldest owed entry.
  task automatic check_entry();
    perm_entry_t want;
    if (owed_entries.size() == 0) begin
      $display("%0t: unexpected result, element %0d is_last %0b", $time, out_element,
               out_is_last);
      fail_tally++;
    end else begin
      want = owed_entries.pop_front();
      if (out_element !== want.element) begin
        $display("%0t: element expected %0d got %0d", $time, want.element, out_element);
        fail_tally++;
      end
      if (out_is_last !== want.is_last) begin
        $display("%0t: is_last expected %0b got %0b", $time, want.is_last, out_is_last);
        fail_tally++;
      end
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      length_reg = LENGTH_RESET;
      restore_identity();
      owed_entries.delete();
    end else begin
      if (out_valid === 1'b1) check_entry();
      if (psel && penable && pready && paddr == LENGTH_ADDR) begin
        if (pwrite) begin
          // Any length write abandons the permutation in progress.
          length_reg = pwdata[CFG_W-1:0];
          restore_identity();
        end else if (prdata !== APB_W'(length_reg)) begin
          $display("%0t: perm_length read expected %0d got %0d", $time, length_reg, prdata);
          fail_tally++;
        end
      end
      if (start && !busy) shuffle_step(in_random_value);
    end
    mismatch_count <= fail_tally;
    results_owed <= owed_entries.size();
  end

endmodule

[tb/sv/random_permutation_shuffle_test.sv]
// Top of the permutation shuffle testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module random_permutation_shuffle_test;
  import rps_pkg::*;

  localparam logic [PADDR_W-1:0] LENGTH_ADDR = '0;
  localparam int RUN_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [RAND_W-1:0]   in_random_value = '0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [APB_W-1:0]    pwdata = '0;
  wire                 busy;
  wire                 out_valid;
  wire [ELEM_W-1:0]    out_element;
  wire                 out_is_last;
  wire [APB_W-1:0]     prdata;
  wire                 pready;
  int                  mismatch_count;
  int                  results_owed;
  int                  cycle_count = 0;
  int unsigned         phase_len;

  random_permutation_shuffle dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_random_value(in_random_value),
    .out_valid(out_valid), .out_element(out_element), .out_is_last(out_is_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  random_permutation_shuffle_checker #(.LENGTH_ADDR(LENGTH_ADDR)) chk (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_random_value(in_random_value),
    .out_valid(out_valid), .out_element(out_element), .out_is_last(out_is_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("random_permutation_shuffle verification failed");
      $finish;
    end
  end

  // Mostly full-width words, sometimes small ones from 0 to 70.
  function automatic logic [RAND_W-1:0] pick_word();
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(3) == 0) return RAND_W'($urandom_range(70));
    return raw[RAND_W-1:0];
  endfunction

  // Offer one random word, idling first at the given rate, and wait until busy is low again.
  task automatic offer_word(input logic [RAND_W-1:0] word, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_random_value <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop offering words and let every owed result arrive and the block go quiet.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write perm_length, then read it back; noise rides in the unused upper bits.
  task automatic program_length(input logic [CFG_W-1:0] len, input logic [APB_W-1:0] noise);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LENGTH_ADDR;
    pwdata <= {noise[APB_W-1:CFG_W], len};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random phase: program a length, then a run of words at one idle rate.
  task automatic random_phase(input logic [CFG_W-1:0] len, input int words, input int idle_pct,
                              input bit pause_after_first);
    int unsigned eff;
    eff = (len == 0) ? 1 : ((len > MAX_LENGTH) ? MAX_LENGTH : len);
    program_length(len, $urandom);
    for (int k = 0; k < words; k++) begin
      offer_word(pick_word(), idle_pct);
      // Hold the sender off until the first permutation has fully streamed out.
      if (pause_after_first && k == eff - 1) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset length of 64: a partial permutation with both word extremes.
    offer_word('0, 0);
    offer_word({RAND_W{1'b1}}, 0);
    offer_word(pick_word(), 0);
    drain_results();

    // Length zero acts as one; this write also abandons the partial permutation.
    program_length(CFG_W'(0), '1);
    offer_word('0, 0);
    offer_word({RAND_W{1'b1}}, 0);
    drain_results();

    // Length one: one result per word.
    program_length(CFG_W'(1), '0);
    offer_word(pick_word(), 0);
    offer_word({RAND_W{1'b1}}, 0);
    drain_results();

    // Length two: swap and no-swap first steps.
    program_length(CFG_W'(2), $urandom);
    offer_word('0, 0);
    offer_word({RAND_W{1'b1}}, 0);
    offer_word(RAND_W'(1), 0);
    offer_word('0, 0);
    drain_results();

    // Oversized length acts as 64; abandoned by a write to three mid-way.
    program_length({CFG_W{1'b1}}, $urandom);
    offer_word({RAND_W{1'b1}}, 0);
    offer_word(RAND_W'(63), 0);
    offer_word(pick_word(), 0);
    drain_results();
    program_length(CFG_W'(3), $urandom);
    offer_word(RAND_W'(2), 0);
    offer_word({RAND_W{1'b1}}, 0);
    offer_word('0, 0);
    offer_word(pick_word(), 0);
    offer_word(pick_word(), 0);
    drain_results();

    // Random phases over several lengths and idle rates.
    phase_len = $urandom_range(2, 10);
    random_phase(CFG_W'(phase_len), 16, 0, 1'b1);
    phase_len = $urandom_range(64, 127);
    random_phase(CFG_W'(phase_len), 64, 46, 1'b0);
    phase_len = $urandom_range(0, 16);
    random_phase(CFG_W'(phase_len), 16, 27, 1'b0);
    phase_len = $urandom_range(3, 12);
    random_phase(CFG_W'(phase_len), 15, 46, 1'b0);

    if (mismatch_count == 0) begin
      $display("random_permutation_shuffle verification clean");
    end else begin
      $display("random_permutation_shuffle verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rps_pkg.sv
rtl/random_permutation_shuffle.sv
tb/sv/random_permutation_shuffle_checker.sv
tb/sv/random_permutation_shuffle_test.sv
